// ===== rtl/core/bounded_mailbox_queue_macros.svh =====
// Assertion macros shared by the mailbox queue RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BOUNDED_MAILBOX_QUEUE_MACROS_SVH
`define BOUNDED_MAILBOX_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mailbox queue check failed");

// Next-cycle implication, checked outside reset.
`define BMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mailbox queue check failed");

`endif

// ===== rtl/core/bmq_pkg.sv =====
// Shared types, constants and command codes for the mailbox queue.
// Depends on nothing; used by bmq_cell and bounded_mailbox_queue.
package bmq_pkg;

  // Queue capacity and the widths that follow from it.
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LIMIT_W     = 5;
  localparam int CMD_W       = 3;

  // Command codes; the spare code is a no-operation.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH        = 3'd0,
    CMD_POP         = 3'd1,
    CMD_REMOVE      = 3'd2,
    CMD_SCHED_DRAIN = 3'd3,
    CMD_CLEAR_DRAIN = 3'd4,
    CMD_ACQUIRE     = 3'd5,
    CMD_RELEASE     = 3'd6
  } bmq_cmd_e;

  // One queue entry: the four message keys.
  typedef struct packed {
    logic [63:0] entity;
    logic [31:0] message;
    logic [63:0] route;
    logic [63:0] request;
  } bmq_entry_t;

  // Per-cell control from the queue controller.
  typedef struct packed {
    logic live;    // cell holds a valid entry
    logic load;    // cell takes the pushed keys
    logic pop;     // whole chain shifts towards the head
    logic remove;  // chain closes the gap behind the first match
  } bmq_cell_ctrl_t;

endpackage

// ===== rtl/core/bmq_cell.sv =====
// One storage cell of the mailbox queue chain: holds an entry, compares it
// against the remove keys and takes its neighbour's entry on a shift. Uses bmq_pkg.
module bmq_cell import bmq_pkg::*; (
  input  logic           clk_i,
  input  bmq_cell_ctrl_t ctrl_i,
  input  bmq_entry_t     key_i,
  input  bmq_entry_t     next_i,
  input  logic           found_i,
  output logic           found_o,
  output bmq_entry_t     entry_o
);

  bmq_entry_t entry_q;
  logic       hit;
  logic       shift;

  // A live entry matching all four keys; the match ripples down the chain so
  // that only cells at or behind the oldest match close the gap.
  assign hit     = ctrl_i.live && (entry_q == key_i);
  assign found_o = found_i || hit;
  assign shift   = ctrl_i.pop || (ctrl_i.remove && found_o);

  // Entry register: load on push, take the neighbour's entry on a shift.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= key_i;
    end else if (shift) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/core/bounded_mailbox_queue.sv =====
// Mailbox queue: bounded FIFO of message keys built as a chain of 16 cells.
// A result is registered; it appears in the cycle after its command transfer.
// One command per cycle unless a held result stalls; cells update together.
// Reset clears the fill count, drop counter, flags and output valid, and sets
// the depth limit to 16; entry contents are not cleared.
`include "bounded_mailbox_queue_macros.svh"

module bounded_mailbox_queue import bmq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i,
  // Command channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [63:0]        entity_key_i,
  input  logic [31:0]        message_key_i,
  input  logic [63:0]        route_value_i,
  input  logic [63:0]        request_key_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               granted_o,
  output logic [63:0]        out_entity_o,
  output logic [31:0]        out_message_o,
  output logic [63:0]        out_route_o,
  output logic [63:0]        out_request_o,
  output logic [CNT_W-1:0]   occupancy_o,
  output logic [63:0]        drops_seen_o,
  output logic               writer_busy_o,
  output logic               drain_pending_o
);

  logic [LIMIT_W-1:0] limit_q;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [63:0]        drop_q, drop_d;
  logic               writer_q, writer_d;
  logic               drain_q, drain_d;
  logic               out_valid_q;
  logic               granted_q, granted_d;
  bmq_entry_t         out_keys_q, out_keys_d;

  logic               fire;
  logic [CNT_W-1:0]   eff_limit;
  logic               push_ok;
  logic               is_push, is_pop, is_remove;
  logic               remove_hit;
  bmq_entry_t         key;
  bmq_entry_t         cell_entry [QUEUE_DEPTH];
  bmq_entry_t         cell_next  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] found_chain;
  bmq_cell_ctrl_t     cell_ctrl  [QUEUE_DEPTH];

  // Handshakes: the output register parts the two sides.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;

  assign key = '{entity: entity_key_i, message: message_key_i,
                 route: route_value_i, request: request_key_i};

  // Effective limit: zero acts as one, anything above capacity as capacity.
  always_comb begin
    if (limit_q == '0) begin
      eff_limit = CNT_W'(1);
    end else if (int'(limit_q) > QUEUE_DEPTH) begin
      eff_limit = CNT_W'(QUEUE_DEPTH);
    end else begin
      eff_limit = CNT_W'(limit_q);
    end
  end

  assign push_ok    = (fill_q < eff_limit) && (int'(fill_q) < QUEUE_DEPTH);
  assign is_push    = fire && (command_i == CMD_PUSH);
  assign is_pop     = fire && (command_i == CMD_POP) && (fill_q != '0);
  assign is_remove  = fire && (command_i == CMD_REMOVE);
  assign remove_hit = found_chain[QUEUE_DEPTH];

  // Cell chain: cell 0 is the head; the last cell takes zeros on a shift.
  assign found_chain[0] = 1'b0;
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign cell_ctrl[i] = '{
      live:   (fill_q > CNT_W'(i)),
      load:   is_push && push_ok && (fill_q == CNT_W'(i)),
      pop:    is_pop,
      remove: is_remove
    };
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign cell_next[i] = '0;
    end else begin : g_body
      assign cell_next[i] = cell_entry[i+1];
    end
    bmq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .key_i   (key),
      .next_i  (cell_next[i]),
      .found_i (found_chain[i]),
      .found_o (found_chain[i+1]),
      .entry_o (cell_entry[i])
    );
  end

  // Command decode: next fill, counters, flags and the result.
  always_comb begin
    fill_d     = fill_q;
    drop_d     = drop_q;
    writer_d   = writer_q;
    drain_d    = drain_q;
    granted_d  = 1'b0;
    out_keys_d = '0;
    unique case (command_i)
      CMD_PUSH: begin
        if (push_ok) begin
          fill_d    = fill_q + CNT_W'(1);
          granted_d = 1'b1;
        end else begin
          drop_d = drop_q + 64'd1;
        end
      end
      CMD_POP: begin
        if (fill_q != '0) begin
          fill_d     = fill_q - CNT_W'(1);
          granted_d  = 1'b1;
          out_keys_d = cell_entry[0];
        end
      end
      CMD_REMOVE: begin
        if (remove_hit) begin
          fill_d    = fill_q - CNT_W'(1);
          granted_d = 1'b1;
        end
      end
      CMD_SCHED_DRAIN: begin
        if (!writer_q && !drain_q) begin
          drain_d   = 1'b1;
          granted_d = 1'b1;
        end
      end
      CMD_CLEAR_DRAIN: begin
        drain_d = 1'b0;
      end
      CMD_ACQUIRE: begin
        if (!writer_q) begin
          writer_d  = 1'b1;
          drain_d   = 1'b0;
          granted_d = 1'b1;
        end
      end
      CMD_RELEASE: begin
        writer_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control state and configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_W'(QUEUE_DEPTH);
      fill_q      <= '0;
      drop_q      <= '0;
      writer_q    <= 1'b0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (fire) begin
        fill_q      <= fill_d;
        drop_q      <= drop_d;
        writer_q    <= writer_d;
        drain_q     <= drain_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register, loaded on each command transfer.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      granted_q  <= granted_d;
      out_keys_q <= out_keys_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = granted_q;
  assign out_entity_o    = out_keys_q.entity;
  assign out_message_o   = out_keys_q.message;
  assign out_route_o     = out_keys_q.route;
  assign out_request_o   = out_keys_q.request;
  assign occupancy_o     = fill_q;
  assign drops_seen_o    = drop_q;
  assign writer_busy_o   = writer_q;
  assign drain_pending_o = drain_q;

  // The fill count never exceeds the number of cells.
  `BMQ_ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, 1'b1, int'(fill_q) <= QUEUE_DEPTH)
  // An accepted push grows the queue by exactly one entry.
  `BMQ_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, is_push && push_ok, fill_q == $past(fill_q) + CNT_W'(1))
  // The drop counter moves only on a refused push.
  `BMQ_ASSERT_NEXT(a_drop_only_refused, clk_i, rst_ni, !(is_push && !push_ok), drop_q == $past(drop_q))
  // A granted acquire leaves the writer held and no drain pending.
  `BMQ_ASSERT_NEXT(a_acquire_clears, clk_i, rst_ni, fire && (command_i == CMD_ACQUIRE) && !writer_q, writer_q && !drain_q)

endmodule
